// ===== hw/rtl/kge_triple_score_assert.svh =====
// Assertion macros for kge_triple_score
`ifndef KGE_TRIPLE_SCORE_ASSERT_SVH
`define KGE_TRIPLE_SCORE_ASSERT_SVH
// implication checked on every rising clock edge, skipped during reset
`define KGE_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kge assertion failed");
// next-cycle implication
`define KGE_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kge assertion failed");
`endif

// ===== hw/rtl/kge_pkg.sv =====
package kge_pkg;
    localparam int DataWidth = 16;
    localparam int FracBits  = 12;
    localparam int MaxDim    = 1024;
    localparam int AccWidth  = 48;
    localparam int CntWidth  = $clog2(MaxDim + 1);

    typedef enum logic [1:0] {
        MODE_TRANSE   = 2'd0,
        MODE_DISTMULT = 2'd1,
        MODE_COMPLEX  = 2'd2,
        MODE_ROTATE   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_S1, ST_S2, ST_S3, ST_SQRT, ST_OUT
    } state_t;

    typedef struct packed {
        logic load;     // capture input item
        logic stage1;   // first products
        logic stage2;   // combine products
        logic stage3;   // accumulate
        logic sqrt_start;
        logic sqrt_step;
        logic finish;   // load result register
        logic clear;    // clear accumulator after output
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic dist_mode;
        logic sqrt_done;
    } dp_status_t;
endpackage

// ===== hw/rtl/kge_ctrl.sv =====
module kge_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  kge_pkg::dp_status_t status,
    output kge_pkg::dp_cmd_t    cmd
);
    import kge_pkg::*;

    state_t state_reg, state_next;
    logic   ovalid_reg, ovalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

    always_comb begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        if (ovalid_reg && out_ready) begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_S1;
                end
            end
            ST_S1: begin
                cmd.stage1 = 1'b1;
                state_next = ST_S2;
            end
            ST_S2: begin
                cmd.stage2 = 1'b1;
                state_next = ST_S3;
            end
            ST_S3: begin
                cmd.stage3 = 1'b1;
                if (!status.last) begin
                    state_next = ST_IDLE;
                end else if (status.dist_mode) begin
                    state_next = ST_SQRT;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_SQRT: begin
                if (status.sqrt_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.sqrt_step = 1'b1;
                end
            end
            ST_OUT: begin
                // result register is free once the previous score is taken
                if (!ovalid_reg || out_ready) begin
                    cmd.finish  = 1'b1;
                    cmd.clear   = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.sqrt_start = cmd.stage3 & status.last;
    end
endmodule

// ===== hw/rtl/kge_datapath.sv =====
module kge_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [1:0]                           model_mode,
    input  logic [6*kge_pkg::DataWidth:0]        in_item,
    input  kge_pkg::dp_cmd_t                     cmd,
    output kge_pkg::dp_status_t                  status,
    output logic [kge_pkg::AccWidth:0]           result
);
    import kge_pkg::*;

    localparam int DW = DataWidth;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 4;
    // second-stage operands never exceed 22 signed bits
    localparam int QW = 24;
    localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
    localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};
    localparam logic [AccWidth-1:0] BitTop = {2'b01, {(AccWidth-2){1'b0}}};

    logic signed [DW-1:0] hr_reg, hi_reg, rr_reg, ri_reg, tr_reg, ti_reg;
    logic                 last_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [SW-1:0] pre_reg, pim_reg;
    logic signed [AccWidth-1:0] acc_reg;
    logic                 ovf_reg;
    logic [CntWidth-1:0]  cnt_reg;
    logic [AccWidth-1:0]  rem_reg, root_reg, bit_reg;
    logic [AccWidth:0]    result_reg;
    mode_t mode;

    assign mode = mode_t'(model_mode);

    // stage 2: combine first-stage products
    logic signed [SW-1:0] sum_re, sum_im, d_tr, s_pre, s_pim;
    logic signed [SW-1:0] pre_s, pim_s;
    always_comb begin
        sum_re = SW'(p1_reg) - SW'(p2_reg);
        sum_im = SW'(p3_reg) + SW'(p4_reg);
        pre_s  = sum_re >>> FracBits;
        pim_s  = sum_im >>> FracBits;
        d_tr   = SW'(hr_reg) + SW'(rr_reg) - SW'(tr_reg);
        s_pre  = pre_s - SW'(tr_reg);
        s_pim  = pim_s - SW'(ti_reg);
    end

    logic signed [QW-1:0] q1, q2;
    logic signed [2*QW-1:0] m1, m2;
    logic signed [SW-1:0] pre_x, pim_x;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            {last_reg, ti_reg, tr_reg, ri_reg, rr_reg, hi_reg, hr_reg} <= in_item;
        end
        if (cmd.stage1) begin
            p1_reg <= hr_reg * rr_reg;
            p2_reg <= hi_reg * ri_reg;
            p3_reg <= hr_reg * ri_reg;
            p4_reg <= hi_reg * rr_reg;
        end
        if (cmd.stage2) begin
            pim_reg <= (mode == MODE_ROTATE) ? s_pim : pim_s;
            unique case (mode)
                MODE_TRANSE:   pre_reg <= d_tr;
                MODE_DISTMULT: pre_reg <= SW'(p1_reg) >>> FracBits;
                MODE_COMPLEX:  pre_reg <= pre_s;
                MODE_ROTATE:   pre_reg <= s_pre;
                default:       pre_reg <= pre_s;
            endcase
        end
    end

    // stage 3: second multiply and accumulate
    logic signed [2*QW-1:0] term;
    logic signed [AccWidth+1:0] acc_sum;
    always_comb begin
        pre_x = pre_reg;
        pim_x = pim_reg;
        q1 = QW'(pre_x);
        q2 = QW'(pim_x);
        m1 = '0;
        m2 = '0;
        unique case (mode)
            MODE_TRANSE: begin
                m1 = q1 * q1;
            end
            MODE_DISTMULT: begin
                m1 = (q1 * (2*QW)'(tr_reg)) >>> FracBits;
            end
            MODE_COMPLEX: begin
                m1 = q1 * (2*QW)'(tr_reg);
                m2 = q2 * (2*QW)'(ti_reg);
            end
            MODE_ROTATE: begin
                m1 = q1 * q1;
                m2 = q2 * q2;
            end
            default: ;
        endcase
        term = m1 + m2;
        if (mode == MODE_COMPLEX) begin
            term = term >>> FracBits;
        end
        acc_sum = (AccWidth+2)'(acc_reg) + (AccWidth+2)'(term);
    end

    // isqrt: one result bit per step; the first step picks up the accumulator
    logic [AccWidth-1:0] rb, rem_cur;
    always_comb begin
        rem_cur = rem_reg;
        if (bit_reg == BitTop) begin
            rem_cur = acc_reg[AccWidth-1] ? '0 : acc_reg;
        end
        rb = root_reg + bit_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (cmd.clear) begin
            acc_reg <= '0;
            ovf_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (cmd.stage3 && cnt_reg < CntWidth'(MaxDim)) begin
            cnt_reg <= cnt_reg + CntWidth'(1);
            if (acc_sum > (AccWidth+2)'(AccMax)) begin
                acc_reg <= AccMax;
                ovf_reg <= 1'b1;
            end else if (acc_sum < (AccWidth+2)'(AccMin)) begin
                acc_reg <= AccMin;
                ovf_reg <= 1'b1;
            end else begin
                acc_reg <= acc_sum[AccWidth-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            // accumulator settles on this edge, so it is read by the first step
            root_reg <= '0;
            bit_reg  <= BitTop;
            rem_reg  <= '0;
        end else if (cmd.sqrt_step) begin
            bit_reg <= bit_reg >> 2;
            if (rem_cur >= rb) begin
                rem_reg  <= rem_cur - rb;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                rem_reg  <= rem_cur;
                root_reg <= root_reg >> 1;
            end
        end
        if (cmd.finish) begin
            result_reg <= status.dist_mode ? {ovf_reg, -root_reg} : {ovf_reg, acc_reg};
        end
    end

    assign status.last      = last_reg;
    assign status.dist_mode = (mode == MODE_TRANSE) || (mode == MODE_ROTATE);
    assign status.sqrt_done = (bit_reg == '0);
    assign result           = result_reg;
endmodule

// ===== hw/rtl/kge_triple_score.sv =====
// kge_triple_score: streaming knowledge-graph triple scorer.
// Slave stream: one embedding element per transaction; tdata carries
// head_re, head_im, rel_re, rel_im, tail_re, tail_im (16 bits each, low
// first), tlast marks the last element and triggers one score.
// Master stream: tdata carries score (48-bit signed Q.12) then saturated.
// model_mode (0 TransE, 1 DistMult, 2 ComplEx, 3 RotatE) is written via cfg_wr_en
// and cfg_wr_data; the user must do so only while idle, not enforced by the block.
// Each element passes through capture, product, combine and accumulate
// steps; after a non-last element the next is taken once accumulate ends.
// On tlast, distance modes run a one-bit-per-cycle root, then the score
// lands in an output register once that register is free.
// A held output register lets the next elements stream in; a second score
// waits until the first is taken.
// Reset clears mode, accumulator, saturation flag and the output valid.
module kge_triple_score (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,  // head_re, head_im, rel_re, rel_im, tail_re, tail_im
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata   // score[47:0], saturated[48], zero fill
);
    import kge_pkg::*;

    logic [1:0]             mode_reg;
    dp_cmd_t                cmd;
    dp_status_t             status;
    logic [AccWidth:0]      result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 2'd0;
        end else if (cfg_wr_en) begin
            mode_reg <= cfg_wr_data;
        end
    end

    kge_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    kge_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .model_mode(mode_reg),
        .in_item   ({s_tlast, s_tdata}),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

    assign m_tdata = {7'd0, result};
endmodule

// ===== hw/rtl/kge_checker.sv =====
`include "kge_triple_score_assert.svh"
module kge_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    `KGE_ASSERT_NXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `KGE_ASSERT_NXT(a_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `KGE_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `KGE_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[55:49] == 7'd0)
endmodule

bind kge_triple_score kge_checker u_kge_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
